/* hdl/pva_pkg.sv */
// Shared types and constants for the priority voice allocator.
package pva_pkg;

	// Request codes carried on req_type.
	typedef enum logic [1:0] {
		REQ_ACQUIRE  = 2'd0,
		REQ_RELEASE  = 2'd1,
		REQ_TICK     = 2'd2,
		REQ_STOP_ALL = 2'd3
	} req_type_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} pva_state_t;

	// Priorities stamped on a granted voice.
	localparam logic [1:0] PRIO_ONESHOT = 2'd1;
	localparam logic [1:0] PRIO_LOOP    = 2'd2;

	// Tick counter saturation point.
	localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

	// Per-entry control into the candidate scan unit.
	typedef struct packed {
		logic clear;    // start of a new acquire: drop all candidates
		logic vld;      // entry data is present this cycle
		logic active;   // entry is active
		logic playing;  // entry's sound still plays
	} scan_ctl_t;

	// Candidate flags out of the scan unit.
	typedef struct packed {
		logic free_found;
		logic fin_found;
		logic steal_found;
	} scan_res_t;

endpackage

/* hdl/pva_cand_scan.sv */
// Candidate tracker: one entry per cycle, keeps first free, first finished and best steal victim.
module pva_cand_scan #(
	parameter int NUM_VOICES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pva_pkg::scan_ctl_t              ctl,
	input  logic [$clog2(NUM_VOICES)-1:0]   idx,
	input  logic [1:0]                      prio,
	input  logic [31:0]                     start_tick,
	input  logic [1:0]                      req_prio,
	output pva_pkg::scan_res_t              res,
	output logic [$clog2(NUM_VOICES)-1:0]   free_idx,
	output logic [$clog2(NUM_VOICES)-1:0]   fin_idx,
	output logic [$clog2(NUM_VOICES)-1:0]   steal_idx
);

	localparam int IW = $clog2(NUM_VOICES);

	pva_pkg::scan_res_t res_q;
	logic [IW-1:0]      free_idx_q;
	logic [IW-1:0]      fin_idx_q;
	logic [IW-1:0]      steal_idx_q;
	logic [1:0]         best_p_q;
	logic [31:0]        best_t_q;

	logic take_free;
	logic take_fin;
	logic take_steal;

	// The one shared comparator: lower priority wins, then the older start.
	always_comb begin
		take_free  = ctl.vld && !res_q.free_found && !ctl.active;
		take_fin   = ctl.vld && !res_q.fin_found && ctl.active && !ctl.playing;
		take_steal = ctl.vld && (prio <= req_prio) &&
		             (!res_q.steal_found || (prio < best_p_q) ||
		              ((prio == best_p_q) && (start_tick < best_t_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (ctl.clear) begin
			res_q <= '0;
		end else begin
			if (take_free)  res_q.free_found  <= 1'b1;
			if (take_fin)   res_q.fin_found   <= 1'b1;
			if (take_steal) res_q.steal_found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_free) free_idx_q <= idx;
		if (take_fin)  fin_idx_q  <= idx;
		if (take_steal) begin
			steal_idx_q <= idx;
			best_p_q    <= prio;
			best_t_q    <= start_tick;
		end
	end

	assign res       = res_q;
	assign free_idx  = free_idx_q;
	assign fin_idx   = fin_idx_q;
	assign steal_idx = steal_idx_q;

endmodule

/* hdl/priority_voice_allocator_core.sv */
// Priority voice allocator: top level with sequencer, voice state and start/priority memory.
//
// Usage
//   A request transaction is taken at a rising edge with start high and busy low.
//   req_type selects acquire, release, tick or stop all; the other fields ride along.
//   Every request yields exactly one result: done pulses for one cycle with
//   granted, granted_slot, stolen and freed_mask valid in that same cycle.
//   The receiver cannot stall; it must take the result in the done cycle.
// Sequencing
//   Release, tick and stop all finish in the accept cycle: done rises on the
//   next cycle and busy never goes high, so they can follow one per cycle.
//   Acquire scans every voice once through the single compare unit, one entry
//   per cycle from the start/priority memory (registered read port), then
//   writes its pick in the commit state; busy stays high through the scan and
//   the commit, and done follows the commit.
// Reset
//   arst_n clears the active and owned marks, the tick count and the sequencer.
//   The start/priority memory is not cleared; an entry only matters once its
//   voice has been granted, which writes it.
module priority_voice_allocator_core #(
	parameter int NUM_VOICES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [1:0]  request_priority,
	input  logic        looping,
	input  logic [5:0]  voice_slot,
	input  logic [31:0] playing_mask,
	output logic        done,
	output logic        granted,
	output logic [4:0]  granted_slot,
	output logic        stolen,
	output logic [31:0] freed_mask
);

	localparam int IW = $clog2(NUM_VOICES);
	localparam int CW = $clog2(NUM_VOICES + 1);
	localparam logic [CW-1:0] SCAN_LAST = CW'(NUM_VOICES);
	localparam logic [5:0]    POOL_SIZE = 6'(NUM_VOICES);

	pva_pkg::pva_state_t state_q, state_d;

	// Voice marks live in flops; priority and start tick share one memory word.
	logic [NUM_VOICES-1:0] voice_active_q;
	logic [NUM_VOICES-1:0] voice_owned_q;
	logic [31:0]           tick_q;
	logic [33:0]           voice_mem [NUM_VOICES];
	logic [33:0]           rdata_s1;

	// Request fields held across the acquire scan.
	logic [1:0]            req_prio_q;
	logic                  loop_q;
	logic [NUM_VOICES-1:0] playing_q;

	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	logic          done_q;
	logic          granted_q;
	logic [4:0]    granted_slot_q;
	logic          stolen_q;
	logic [31:0]   freed_mask_q;

	// Sequencer outputs
	logic          accept;
	logic          is_acquire;
	logic          rd_en;
	logic          commit;
	logic [IW-1:0] rd_idx;

	pva_pkg::scan_ctl_t scan_ctl;
	pva_pkg::scan_res_t scan_res;
	logic [IW-1:0]      free_idx;
	logic [IW-1:0]      fin_idx;
	logic [IW-1:0]      steal_idx;

	// Commit decision
	logic                  pick_vld;
	logic [IW-1:0]         pick;
	logic                  pick_freed;
	logic [NUM_VOICES-1:0] pick_onehot;
	logic [1:0]            new_prio;

	// Immediate request results
	logic [NUM_VOICES-1:0] tick_freed;
	logic                  release_ok;

	assign is_acquire = (pva_pkg::req_type_t'(req_type) == pva_pkg::REQ_ACQUIRE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pva_pkg::ST_IDLE: begin
				if (start && is_acquire) state_d = pva_pkg::ST_SCAN;
			end
			pva_pkg::ST_SCAN: begin
				if (cnt_q == SCAN_LAST) state_d = pva_pkg::ST_COMMIT;
			end
			pva_pkg::ST_COMMIT: begin
				state_d = pva_pkg::ST_IDLE;
			end
			default: state_d = pva_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy   = 1'b1;
		accept = 1'b0;
		rd_en  = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			pva_pkg::ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			pva_pkg::ST_SCAN: begin
				rd_en = (cnt_q < SCAN_LAST);
			end
			pva_pkg::ST_COMMIT: begin
				commit = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	assign rd_idx = cnt_q[IW-1:0];

	// Scan entry: issued in the previous cycle, read data now registered.
	always_comb begin
		scan_ctl.clear   = accept && is_acquire;
		scan_ctl.vld     = rd_vld_s1;
		scan_ctl.active  = voice_active_q[rd_idx_s1];
		scan_ctl.playing = playing_q[rd_idx_s1];
	end

	pva_cand_scan #(
		.NUM_VOICES (NUM_VOICES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (rd_idx_s1),
		.prio       (rdata_s1[33:32]),
		.start_tick (rdata_s1[31:0]),
		.req_prio   (req_prio_q),
		.res        (scan_res),
		.free_idx   (free_idx),
		.fin_idx    (fin_idx),
		.steal_idx  (steal_idx)
	);

	// Free slot first, then a finished voice, then a steal victim.
	always_comb begin
		pick_vld   = 1'b1;
		pick_freed = 1'b0;
		pick       = free_idx;
		if (scan_res.free_found) begin
			pick = free_idx;
		end else if (scan_res.fin_found) begin
			pick       = fin_idx;
			pick_freed = 1'b1;
		end else if (scan_res.steal_found) begin
			pick       = steal_idx;
			pick_freed = 1'b1;
		end else begin
			pick_vld = 1'b0;
		end
		for (int i = 0; i < NUM_VOICES; i++) begin
			pick_onehot[i] = (pick == IW'(i));
		end
		new_prio = loop_q ? pva_pkg::PRIO_LOOP : pva_pkg::PRIO_ONESHOT;
	end

	assign tick_freed = voice_active_q & ~voice_owned_q & ~playing_mask[NUM_VOICES-1:0];
	assign release_ok = (voice_slot < POOL_SIZE);

	// Start/priority memory: one write port at commit, one registered read port.
	always_ff @(posedge clk) begin
		if (commit && pick_vld) voice_mem[pick] <= {new_prio, tick_q};
		rdata_s1 <= voice_mem[rd_idx];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pva_pkg::ST_IDLE;
			cnt_q          <= '0;
			rd_vld_s1      <= 1'b0;
			voice_active_q <= '0;
			voice_owned_q  <= '0;
			tick_q         <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= 1'b0;
			if (accept && is_acquire) begin
				cnt_q <= '0;
			end else if (state_q == pva_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (accept) begin
				unique case (pva_pkg::req_type_t'(req_type))
					pva_pkg::REQ_ACQUIRE: begin
						// result comes after the scan
					end
					pva_pkg::REQ_RELEASE: begin
						done_q <= 1'b1;
						if (release_ok) voice_owned_q[voice_slot[IW-1:0]] <= 1'b0;
					end
					pva_pkg::REQ_TICK: begin
						done_q <= 1'b1;
						if (tick_q != pva_pkg::TICK_MAX) tick_q <= tick_q + 32'd1;
						voice_active_q <= voice_active_q & ~tick_freed;
						voice_owned_q  <= voice_owned_q & ~tick_freed;
					end
					pva_pkg::REQ_STOP_ALL: begin
						done_q <= 1'b1;
						voice_owned_q  <= voice_owned_q & ~voice_active_q;
						voice_active_q <= '0;
					end
					default: done_q <= 1'b1;
				endcase
			end
			if (commit) begin
				done_q <= 1'b1;
				if (pick_vld) begin
					voice_active_q <= voice_active_q | pick_onehot;
					voice_owned_q  <= voice_owned_q | pick_onehot;
				end
			end
		end
	end

	// Held request fields and result payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
		if (accept && is_acquire) begin
			req_prio_q <= request_priority;
			loop_q     <= looping;
			playing_q  <= playing_mask[NUM_VOICES-1:0];
		end
		if (accept && !is_acquire) begin
			granted_q      <= 1'b0;
			granted_slot_q <= '0;
			stolen_q       <= 1'b0;
			case (pva_pkg::req_type_t'(req_type))
				pva_pkg::REQ_TICK:     freed_mask_q <= 32'(tick_freed);
				pva_pkg::REQ_STOP_ALL: freed_mask_q <= 32'(voice_active_q);
				default:               freed_mask_q <= '0;
			endcase
		end
		if (commit) begin
			granted_q      <= pick_vld;
			granted_slot_q <= pick_vld ? 5'(pick) : 5'd0;
			stolen_q       <= pick_vld && !scan_res.free_found && !scan_res.fin_found;
			freed_mask_q   <= pick_freed ? 32'(pick_onehot) : 32'd0;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign granted_slot = granted_slot_q;
	assign stolen       = stolen_q;
	assign freed_mask   = freed_mask_q;

endmodule
